@@ rtl/csvfs_pkg.sv @@
// ----------------------------------------------------------------------------
// csvfs_pkg
// Types, constants and helpers shared by the CSV field splitter modules.
// ----------------------------------------------------------------------------
package csvfs_pkg;

	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_BYTE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_ENABLE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE_BYTE       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE_ENABLE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BYTE      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_ENABLE    = 3'd5;

	typedef struct packed {
		logic [7:0] delimiter_byte;
		logic       delimiter_enable;
		logic [7:0] quote_byte;
		logic       quote_enable;
		logic [7:0] escape_byte;
		logic       escape_enable;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] cell_byte;
		logic       quoted;
		logic       row_ended;
	} slot_t;

	typedef struct packed {
		slot_t [MAX_RESULTS-1:0] slot;
		logic [1:0]              count;
	} bundle_t;

	function automatic slot_t make_byte(input logic [7:0] b);
		slot_t s;
		s.kind      = KIND_BYTE;
		s.cell_byte = b;
		s.quoted    = 1'b0;
		s.row_ended = 1'b0;
		return s;
	endfunction

	function automatic slot_t make_end(input logic q, input logic re);
		slot_t s;
		s.kind      = KIND_END;
		s.cell_byte = 8'd0;
		s.quoted    = q;
		s.row_ended = re;
		return s;
	endfunction

endpackage

@@ rtl/csv_field_splitter_core.sv @@
// ----------------------------------------------------------------------------
// csv_field_splitter_core
// Streaming CSV cell splitter with configurable delimiter, quote and escape.
// ----------------------------------------------------------------------------
// The block takes one document byte per cycle and gives zero to three results
// for it: content bytes of the current cell and cell-end markers, with
// run_last set on the last result of each byte. A byte is parsed in the cycle
// it is accepted, and its results wait in a queue of QUEUE_DEPTH bundles; the
// output side hands out one result per cycle while out_stall is low, so the
// sustained input rate is one byte per cycle when each byte gives at most one
// result, and otherwise is set by the output. The input stalls only when the
// queue is full. The user must write configuration registers through cfg_we,
// cfg_index and cfg_data while the block is idle; the block has no check for it.
module csv_field_splitter_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [csvfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [csvfs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          data_byte,
	input  logic                                end_of_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                result_kind,
	output logic [7:0]                          cell_byte,
	output logic                                cell_was_quoted,
	output logic                                row_ended,
	output logic                                run_last
);

	csvfs_pkg::cfg_t    cfg_q;
	csvfs_pkg::bundle_t front_bundle;
	csvfs_pkg::bundle_t queue_head;
	logic               take;
	logic               push;
	logic               pop;
	logic               queue_full;
	logic               queue_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter_byte   <= 8'd44;
			cfg_q.delimiter_enable <= 1'b1;
			cfg_q.quote_byte       <= 8'd34;
			cfg_q.quote_enable     <= 1'b1;
			cfg_q.escape_byte      <= 8'd92;
			cfg_q.escape_enable    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csvfs_pkg::CFG_DELIMITER_BYTE:   cfg_q.delimiter_byte   <= cfg_data;
				csvfs_pkg::CFG_DELIMITER_ENABLE: cfg_q.delimiter_enable <= cfg_data[0];
				csvfs_pkg::CFG_QUOTE_BYTE:       cfg_q.quote_byte       <= cfg_data;
				csvfs_pkg::CFG_QUOTE_ENABLE:     cfg_q.quote_enable     <= cfg_data[0];
				csvfs_pkg::CFG_ESCAPE_BYTE:      cfg_q.escape_byte      <= cfg_data;
				csvfs_pkg::CFG_ESCAPE_ENABLE:    cfg_q.escape_enable    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = queue_full;
	assign take     = in_valid && !in_stall;

	csvfs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.take        (take),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.push        (push),
		.bundle      (front_bundle)
	);

	csvfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_bundle),
		.pop       (pop),
		.head      (queue_head),
		.not_empty (queue_valid),
		.full      (queue_full)
	);

	csvfs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (queue_head),
		.head_valid      (queue_valid),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_kind     (result_kind),
		.cell_byte       (cell_byte),
		.cell_was_quoted (cell_was_quoted),
		.row_ended       (row_ended),
		.run_last        (run_last)
	);

endmodule

@@ rtl/csvfs_front.sv @@
// ----------------------------------------------------------------------------
// csvfs_front
// Parses one byte per cycle while take is high and produces the bundle of results it causes.
// ----------------------------------------------------------------------------
module csvfs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  csvfs_pkg::cfg_t    cfg,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               end_of_data,
	output logic               push,
	output csvfs_pkg::bundle_t bundle
);

	typedef enum logic [1:0] {
		PH_START,
		PH_PLAIN,
		PH_QUOTED,
		PH_CLOSED
	} phase_t;

	phase_t phase_q;
	logic   cell_quoted_q;
	logic   row_pending_q;
	logic   escape_pending_q;
	logic   skip_lf_q;

	phase_t ph;
	logic   cq;
	logic   rp;
	logic   ep;
	logic   sk;
	logic   done;
	logic   is_delim;
	logic   is_quote;
	logic   is_esc;
	logic   is_brk;
	logic [1:0] cnt;
	csvfs_pkg::slot_t [csvfs_pkg::MAX_RESULTS-1:0] slots;

	always_comb begin
		ph    = phase_q;
		cq    = cell_quoted_q;
		rp    = row_pending_q;
		ep    = escape_pending_q;
		sk    = skip_lf_q;
		done  = 1'b0;
		cnt   = 2'd0;
		slots = '0;
		is_delim = cfg.delimiter_enable && (data_byte == cfg.delimiter_byte);
		is_quote = cfg.quote_enable && (data_byte == cfg.quote_byte);
		is_esc   = cfg.escape_enable && (data_byte == cfg.escape_byte);
		is_brk   = (data_byte == csvfs_pkg::CH_LF) || (data_byte == csvfs_pkg::CH_CR);

		if (sk) begin
			sk = 1'b0;
			if (data_byte == csvfs_pkg::CH_LF) begin
				done = 1'b1;
			end
		end
		if (!done && ep) begin
			ep = 1'b0;
			slots[cnt] = csvfs_pkg::make_byte(data_byte);
			cnt = cnt + 2'd1;
			done = 1'b1;
		end
		if (!done) begin
			unique case (ph)
				PH_START: begin
					if (is_delim) begin
						slots[cnt] = csvfs_pkg::make_end(cq, 1'b0);
						cnt = cnt + 2'd1;
						cq = 1'b0;
						rp = 1'b1;
						ph = PH_START;
					end else if (is_brk) begin
						if (rp) begin
							slots[cnt] = csvfs_pkg::make_end(cq, 1'b1);
							cnt = cnt + 2'd1;
							cq = 1'b0;
							rp = 1'b0;
							ph = PH_START;
						end
						if (data_byte == csvfs_pkg::CH_CR) begin
							sk = 1'b1;
						end
					end else if (is_quote) begin
						cq = 1'b1;
						ph = PH_QUOTED;
					end else begin
						cq = 1'b0;
						ph = PH_PLAIN;
						if (is_esc) begin
							ep = 1'b1;
						end else begin
							slots[cnt] = csvfs_pkg::make_byte(data_byte);
							cnt = cnt + 2'd1;
						end
					end
				end
				PH_PLAIN: begin
					if (is_esc) begin
						ep = 1'b1;
					end else if (is_delim || is_brk) begin
						slots[cnt] = csvfs_pkg::make_end(cq, is_brk && !is_delim);
						cnt = cnt + 2'd1;
						rp = !(is_brk && !is_delim);
						cq = 1'b0;
						ph = PH_START;
						if (!is_delim && data_byte == csvfs_pkg::CH_CR) begin
							sk = 1'b1;
						end
					end else begin
						slots[cnt] = csvfs_pkg::make_byte(data_byte);
						cnt = cnt + 2'd1;
					end
				end
				PH_QUOTED: begin
					if (is_esc) begin
						ep = 1'b1;
					end else if (is_quote) begin
						ph = PH_CLOSED;
					end else begin
						slots[cnt] = csvfs_pkg::make_byte(data_byte);
						cnt = cnt + 2'd1;
					end
				end
				PH_CLOSED: begin
					if (is_quote) begin
						slots[cnt] = csvfs_pkg::make_byte(cfg.quote_byte);
						cnt = cnt + 2'd1;
						ph = PH_QUOTED;
					end else if (is_delim || is_brk) begin
						slots[cnt] = csvfs_pkg::make_end(cq, !is_delim);
						cnt = cnt + 2'd1;
						rp = is_delim;
						cq = 1'b0;
						ph = PH_START;
						if (!is_delim && data_byte == csvfs_pkg::CH_CR) begin
							sk = 1'b1;
						end
					end else begin
						slots[cnt] = csvfs_pkg::make_byte(cfg.quote_byte);
						cnt = cnt + 2'd1;
						ph = PH_PLAIN;
						if (is_esc) begin
							ep = 1'b1;
						end else begin
							slots[cnt] = csvfs_pkg::make_byte(data_byte);
							cnt = cnt + 2'd1;
						end
					end
				end
			endcase
		end
		if (end_of_data) begin
			if (ph != PH_START || rp) begin
				slots[cnt] = csvfs_pkg::make_end(cq, 1'b1);
				cnt = cnt + 2'd1;
			end
			ph = PH_START;
			cq = 1'b0;
			rp = 1'b0;
			ep = 1'b0;
			sk = 1'b0;
		end
		bundle.slot  = slots;
		bundle.count = cnt;
		push         = take && (cnt != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_START;
			cell_quoted_q    <= 1'b0;
			row_pending_q    <= 1'b0;
			escape_pending_q <= 1'b0;
			skip_lf_q        <= 1'b0;
		end else if (take) begin
			phase_q          <= ph;
			cell_quoted_q    <= cq;
			row_pending_q    <= rp;
			escape_pending_q <= ep;
			skip_lf_q        <= sk;
		end
	end

endmodule

@@ rtl/csvfs_queue.sv @@
// ----------------------------------------------------------------------------
// csvfs_queue
// Short first-in first-out queue of result bundles between parser and output.
// ----------------------------------------------------------------------------
module csvfs_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csvfs_pkg::bundle_t push_data,
	input  logic               pop,
	output csvfs_pkg::bundle_t head,
	output logic               not_empty,
	output logic               full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	csvfs_pkg::bundle_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == FULL_CNT);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/csvfs_back.sv @@
// ----------------------------------------------------------------------------
// csvfs_back
// Holds one result bundle and hands its results out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module csvfs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  csvfs_pkg::bundle_t head,
	input  logic               head_valid,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [7:0]         cell_byte,
	output logic               cell_was_quoted,
	output logic               row_ended,
	output logic               run_last
);

	csvfs_pkg::bundle_t bundle_q;
	logic [1:0]         idx_q;
	logic               hold_q;
	csvfs_pkg::slot_t   cur;
	logic               advance;
	logic               load;

	assign cur             = bundle_q.slot[idx_q];
	assign result_kind     = cur.kind;
	assign cell_byte       = cur.cell_byte;
	assign cell_was_quoted = cur.quoted;
	assign row_ended       = cur.row_ended;
	assign run_last        = (idx_q == (bundle_q.count - 2'd1));
	assign out_valid       = hold_q;
	assign advance         = hold_q && !out_stall;
	assign load            = !hold_q || (advance && run_last);
	assign pop             = load && head_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			bundle_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			hold_q <= head_valid;
			idx_q  <= 2'd0;
		end else if (advance) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule
